@@ rtl/core/pcmdsd_pkg.sv @@
// Shared types and constants for the PCM to DSD sigma-delta modulator core.
// No dependencies; imported by every module of the core.
package pcmdsd_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int INTEGRATOR_BITS = 38;
	localparam int UPSAMPLE_RATIO  = 64;
	localparam int RATIO_LOG2      = $clog2(UPSAMPLE_RATIO);
	localparam int WORD_BITS       = 32;
	localparam int STAGES          = 5;
	localparam int LIMIT_BITS      = 7;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd100;

	// feedback level codes; the unused code reads as no feedback
	localparam logic [1:0] FB_NONE = 2'd0;
	localparam logic [1:0] FB_POS  = 2'd1;
	localparam logic [1:0] FB_NEG  = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
	} pcm_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] dsd_word;
		logic                 channel;
		logic                 last_word;
	} dsd_t;

	typedef struct packed {
		logic prime;
		logic start;
		logic step;
	} lane_ctl_t;

endpackage

@@ rtl/core/pcmdsd_lane.sv @@
// One channel lane: linear interpolator and fifth-order modulator loop.
// Depends on pcmdsd_pkg for constants and the lane control struct.
module pcmdsd_lane #(
	parameter int INTEGRATOR_BITS = pcmdsd_pkg::INTEGRATOR_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  pcmdsd_pkg::lane_ctl_t                      ctl,
	input  logic signed [pcmdsd_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic [pcmdsd_pkg::LIMIT_BITS-1:0]          limit,
	output logic [pcmdsd_pkg::UPSAMPLE_RATIO-1:0]      bits
);
	import pcmdsd_pkg::*;

	localparam int INT_FRAC = INTEGRATOR_BITS - 9;
	localparam int X_FRAC   = SAMPLE_BITS + RATIO_LOG2;
	localparam int SHIFT    = X_FRAC - INT_FRAC;
	localparam int W        = INTEGRATOR_BITS + 4;
	localparam int PW       = SAMPLE_BITS + RATIO_LOG2 + 1;
	localparam int EW       = (PW > W) ? PW : W;

	logic signed [SAMPLE_BITS-1:0]     prev_q;
	logic signed [PW-1:0]              point_q;
	logic signed [SAMPLE_BITS:0]       delta_q;
	logic signed [INTEGRATOR_BITS-1:0] integ_q [STAGES];
	logic [1:0]                        fb_q;
	logic [UPSAMPLE_RATIO-1:0]         bits_q;

	logic signed [EW-1:0]              x_ext;
	logic signed [W-1:0]               x_w;
	logic signed [W-1:0]               lim_w;
	logic signed [W-1:0]               sum_w  [STAGES];
	logic signed [W-1:0]               clamp_w[STAGES];
	logic                              bit_out;

	always_comb begin
		x_ext = EW'(point_q);
		if (SHIFT >= 0) begin
			x_w = W'(x_ext >>> SHIFT);
		end else begin
			x_w = W'(x_ext <<< (-SHIFT));
		end
	end

	always_comb begin
		logic signed [W-1:0] fb_term;
		lim_w = W'(limit) << INT_FRAC;
		for (int i = 0; i < STAGES; i++) begin
			fb_term = '0;
			if (fb_q == FB_POS) begin
				fb_term = W'(1) <<< (INT_FRAC - i);
			end else if (fb_q == FB_NEG) begin
				fb_term = -(W'(1) <<< (INT_FRAC - i));
			end
			if (i == 0) begin
				sum_w[i] = W'(integ_q[i]) + x_w - fb_term;
			end else begin
				sum_w[i] = W'(integ_q[i]) + sum_w[i-1] - fb_term;
			end
			if (sum_w[i] > lim_w) begin
				clamp_w[i] = lim_w;
			end else if (sum_w[i] < -lim_w) begin
				clamp_w[i] = -lim_w;
			end else begin
				clamp_w[i] = sum_w[i];
			end
		end
		bit_out = ~clamp_w[STAGES-1][W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			fb_q   <= FB_NONE;
			for (int i = 0; i < STAGES; i++) begin
				integ_q[i] <= '0;
			end
		end else begin
			if (ctl.prime || ctl.start) begin
				prev_q <= sample;
			end
			if (ctl.step) begin
				fb_q <= bit_out ? FB_POS : FB_NEG;
				for (int i = 0; i < STAGES; i++) begin
					integ_q[i] <= INTEGRATOR_BITS'(clamp_w[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			point_q <= PW'(prev_q) <<< RATIO_LOG2;
			delta_q <= (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(prev_q);
		end else if (ctl.step) begin
			point_q <= point_q + PW'(delta_q);
		end
		if (ctl.step) begin
			bits_q <= {bits_q[UPSAMPLE_RATIO-2:0], bit_out};
		end
	end

	assign bits = bits_q;

endmodule

@@ rtl/core/pcmdsd_merge.sv @@
// Merging stage: holds both lanes' bits of one frame and emits four words L, R, L, R.
// Depends on pcmdsd_pkg for the result struct and word sizes.
module pcmdsd_merge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic [pcmdsd_pkg::UPSAMPLE_RATIO-1:0]  left_bits,
	input  logic [pcmdsd_pkg::UPSAMPLE_RATIO-1:0]  right_bits,
	output logic                                   free,
	output logic                                   dsd_valid,
	input  logic                                   dsd_stall,
	output pcmdsd_pkg::dsd_t                       dsd
);
	import pcmdsd_pkg::*;

	logic [UPSAMPLE_RATIO-1:0] left_q;
	logic [UPSAMPLE_RATIO-1:0] right_q;
	logic [1:0]                idx_q;
	logic                      full_q;
	logic                      take;

	assign take      = full_q && !dsd_stall;
	assign free      = !full_q;
	assign dsd_valid = full_q;

	always_comb begin
		unique case (idx_q)
			2'd0:    dsd.dsd_word = left_q[UPSAMPLE_RATIO-1 -: WORD_BITS];
			2'd1:    dsd.dsd_word = right_q[UPSAMPLE_RATIO-1 -: WORD_BITS];
			2'd2:    dsd.dsd_word = left_q[WORD_BITS-1:0];
			default: dsd.dsd_word = right_q[WORD_BITS-1:0];
		endcase
		dsd.channel   = idx_q[0];
		dsd.last_word = (idx_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (load && !full_q) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
			if (idx_q == 2'd3) begin
				full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !full_q) begin
			left_q  <= left_bits;
			right_q <= right_bits;
		end
	end

endmodule

@@ rtl/core/pcm_to_dsd_sigma_delta_modulator_core.sv @@
// PCM frames in, one sequencer driving two parallel modulator lanes and the word merger.
// A frame is accepted when pcm_valid is high and pcm_stall low; the first frame
// after reset only primes the interpolator and yields no words. Every later frame
// runs 64 modulator steps, one per cycle, on both channels at once, so a frame
// occupies the block while it is taken, for its 64 steps and until it is handed over
// to the merger; the hand-over waits while the merger still holds words. The four words
// (L, R, L, R, earliest bit in the MSB) wait in the merger, so a new frame is
// taken while they drain. The user writes integrator_limit through cfg_valid/cfg_data
// only while the block is idle; the block itself does not enforce this.
module pcm_to_dsd_sigma_delta_modulator_core #(
	parameter int INTEGRATOR_BITS = pcmdsd_pkg::INTEGRATOR_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pcm_valid,
	output logic                               pcm_stall,
	input  pcmdsd_pkg::pcm_t                   pcm,
	output logic                               dsd_valid,
	input  logic                               dsd_stall,
	output pcmdsd_pkg::dsd_t                   dsd,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pcmdsd_pkg::LIMIT_BITS-1:0]  cfg_data
);
	import pcmdsd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic                      primed_q;
	logic [RATIO_LOG2-1:0]     step_q;
	logic [LIMIT_BITS-1:0]     limit_q;
	logic                      accept;
	logic                      merge_free;
	lane_ctl_t                 ctl;
	logic [UPSAMPLE_RATIO-1:0] left_bits;
	logic [UPSAMPLE_RATIO-1:0] right_bits;

	assign pcm_stall = (state_q != ST_IDLE);
	assign accept    = pcm_valid && !pcm_stall;
	assign cfg_ready = 1'b1;

	assign ctl = '{
		prime: accept && !primed_q,
		start: accept && primed_q,
		step:  (state_q == ST_RUN)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			primed_q <= 1'b0;
			step_q   <= '0;
			limit_q  <= LIMIT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						primed_q <= 1'b1;
						step_q   <= '0;
						if (primed_q) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == RATIO_LOG2'(UPSAMPLE_RATIO - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (merge_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	pcmdsd_lane #(
		.INTEGRATOR_BITS(INTEGRATOR_BITS)
	) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (pcm.left_sample),
		.limit  (limit_q),
		.bits   (left_bits)
	);

	pcmdsd_lane #(
		.INTEGRATOR_BITS(INTEGRATOR_BITS)
	) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (pcm.right_sample),
		.limit  (limit_q),
		.bits   (right_bits)
	);

	pcmdsd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (state_q == ST_DONE),
		.left_bits  (left_bits),
		.right_bits (right_bits),
		.free       (merge_free),
		.dsd_valid  (dsd_valid),
		.dsd_stall  (dsd_stall),
		.dsd        (dsd)
	);

endmodule

@@ bench/dsd_stream_checker.sv @@
// Checker for the PCM to DSD sigma-delta modulator core: watches the PCM, DSD and limit channels,
// predicts the four DSD words of every frame after the priming frame and compares them in order.
// Depends on pcmdsd_pkg for the payload types, widths and feedback codes.
`timescale 1ns / 100ps

module dsd_stream_checker #(
	parameter int INTEGRATOR_BITS = pcmdsd_pkg::INTEGRATOR_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pcm_valid,
	input  logic                               pcm_stall,
	input  pcmdsd_pkg::pcm_t                   pcm,
	input  logic                               dsd_valid,
	input  logic                               dsd_stall,
	input  pcmdsd_pkg::dsd_t                   dsd,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [pcmdsd_pkg::LIMIT_BITS-1:0]  cfg_data,
	output int                                 mismatch_count,
	output int                                 words_due_count
);
	import pcmdsd_pkg::*;

	localparam int INT_FRAC    = INTEGRATOR_BITS - 9;
	localparam int POINT_SHIFT = SAMPLE_BITS + RATIO_LOG2 - INT_FRAC;
	localparam logic CH_LEFT   = 1'b0;
	localparam logic CH_RIGHT  = 1'b1;

	logic signed [SAMPLE_BITS-1:0]     last_left;
	logic signed [SAMPLE_BITS-1:0]     last_right;
	logic                              have_frame;
	logic signed [INTEGRATOR_BITS-1:0] acc [2][STAGES];
	logic [1:0]                        fb_code [2];
	logic [LIMIT_BITS-1:0]             clamp_mag;
	dsd_t                              dsd_words_due [$];
	dsd_t                              want;
	int                                failures;
	int                                due;

	assign mismatch_count  = failures;
	assign words_due_count = due;

	// floor shift towards the integrator format
	function automatic longint scale_point(input longint p);
		if (POINT_SHIFT > 0)
			return p >>> POINT_SHIFT;
		return p <<< (INT_FRAC - SAMPLE_BITS - RATIO_LOG2);
	endfunction

	function automatic logic modulate_point(input int ch, input longint x);
		longint unit_v;
		longint lim;
		longint q;
		longint s [STAGES];
		int     i;
		unit_v = longint'(1) <<< INT_FRAC;
		lim    = longint'(clamp_mag) * unit_v;
		case (fb_code[ch])
			FB_POS:  q = unit_v;
			FB_NEG:  q = -unit_v;
			default: q = 0;
		endcase
		for (i = 0; i < STAGES; i++)
			s[i] = acc[ch][i];
		s[0] = s[0] + x - q;
		for (i = 1; i < STAGES; i++)
			s[i] = s[i] + s[i-1] - (q >>> i);
		// clamp only after the whole chain has settled
		for (i = 0; i < STAGES; i++) begin
			if (s[i] > lim)
				s[i] = lim;
			else if (s[i] < -lim)
				s[i] = -lim;
			acc[ch][i] = s[i][INTEGRATOR_BITS-1:0];
		end
		fb_code[ch] = (s[STAGES-1] >= 0) ? FB_POS : FB_NEG;
		return s[STAGES-1] >= 0;
	endfunction

	function automatic void expand_frame(input pcm_t f);
		logic signed [SAMPLE_BITS-1:0] nl;
		logic signed [SAMPLE_BITS-1:0] nr;
		logic [WORD_BITS-1:0]          wl [2];
		logic [WORD_BITS-1:0]          wr [2];
		longint                        pl;
		longint                        pr;
		dsd_t                          w;
		int                            k;
		nl = f.left_sample;
		nr = f.right_sample;
		if (!have_frame) begin
			last_left  = nl;
			last_right = nr;
			have_frame = 1'b1;
			return;
		end
		wl[0] = '0; wl[1] = '0; wr[0] = '0; wr[1] = '0;
		for (k = 0; k < UPSAMPLE_RATIO; k++) begin
			pl = longint'(last_left) * (UPSAMPLE_RATIO - k) + longint'(nl) * k;
			pr = longint'(last_right) * (UPSAMPLE_RATIO - k) + longint'(nr) * k;
			wl[k / WORD_BITS][WORD_BITS - 1 - (k % WORD_BITS)] = modulate_point(0, scale_point(pl));
			wr[k / WORD_BITS][WORD_BITS - 1 - (k % WORD_BITS)] = modulate_point(1, scale_point(pr));
		end
		last_left  = nl;
		last_right = nr;
		for (k = 0; k < 2; k++) begin
			w.dsd_word = wl[k]; w.channel = CH_LEFT; w.last_word = 1'b0;
			dsd_words_due.push_back(w);
			w.dsd_word = wr[k]; w.channel = CH_RIGHT; w.last_word = (k == 1);
			dsd_words_due.push_back(w);
		end
	endfunction

	function automatic void note_failure(input string what, input dsd_t exp_w, input dsd_t got_w);
		if (failures < 10)
			$display("%s: expected %h ch %0d last %0b, got %h ch %0d last %0b", what,
				exp_w.dsd_word, exp_w.channel, exp_w.last_word,
				got_w.dsd_word, got_w.channel, got_w.last_word);
		failures++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left  = '0;
			last_right = '0;
			have_frame = 1'b0;
			for (int c = 0; c < 2; c++) begin
				fb_code[c] = FB_NONE;
				for (int i = 0; i < STAGES; i++)
					acc[c][i] = '0;
			end
			clamp_mag = LIMIT_RESET;
			dsd_words_due.delete();
			failures = 0;
			due      = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				clamp_mag = cfg_data;
			if (dsd_valid && !dsd_stall) begin
				if (dsd_words_due.size() == 0) begin
					want = '0;
					note_failure("unexpected DSD word", want, dsd);
				end else begin
					want = dsd_words_due.pop_front();
					if (want.dsd_word !== dsd.dsd_word || want.channel !== dsd.channel ||
					    want.last_word !== dsd.last_word)
						note_failure("DSD word mismatch", want, dsd);
				end
			end
			if (pcm_valid && !pcm_stall)
				expand_frame(pcm);
			due = dsd_words_due.size();
		end
	end

endmodule

@@ bench/pcm_to_dsd_sigma_delta_modulator_core_tb.sv @@
// Testbench top for the PCM to DSD sigma-delta modulator core: drives frames and limit
// writes under several idle and stall patterns; dsd_stream_checker does the comparison.
// Depends on pcmdsd_pkg, the core and bench/dsd_stream_checker.sv.
`timescale 1ns / 100ps

module pcm_to_dsd_sigma_delta_modulator_core_tb;
	import pcmdsd_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 600;
	localparam int PHASE_ITEMS   = 56;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_ALT = {(SAMPLE_BITS/2){2'b10}};

	logic                  clk;
	logic                  arst_n;
	logic                  pcm_valid;
	logic                  pcm_stall;
	pcm_t                  pcm;
	logic                  dsd_valid;
	logic                  dsd_stall;
	dsd_t                  dsd;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [LIMIT_BITS-1:0] cfg_data;
	int                    mismatch_count;
	int                    words_due;
	int                    idle_pct;
	int                    stall_pct;
	logic                  hold_req;
	int                    cycles;

	pcm_to_dsd_sigma_delta_modulator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pcm_valid (pcm_valid),
		.pcm_stall (pcm_stall),
		.pcm       (pcm),
		.dsd_valid (dsd_valid),
		.dsd_stall (dsd_stall),
		.dsd       (dsd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dsd_stream_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.pcm_valid       (pcm_valid),
		.pcm_stall       (pcm_stall),
		.pcm             (pcm),
		.dsd_valid       (dsd_valid),
		.dsd_stall       (dsd_stall),
		.dsd             (dsd),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.words_due_count (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls, or one long hold when requested
	initial begin
		dsd_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				dsd_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				dsd_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// call at a falling edge; returns at the falling edge after the request is taken
	task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
	                          input logic signed [SAMPLE_BITS-1:0] r);
		pcm_t f;
		f.left_sample  = l;
		f.right_sample = r;
		while ($urandom_range(99) < idle_pct) begin
			pcm_valid <= 1'b0;
			@(negedge clk);
		end
		pcm_valid <= 1'b1;
		pcm       <= f;
		@(posedge clk);
		while (pcm_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		pcm_valid <= 1'b0;
		wait (words_due == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
		input logic signed [SAMPLE_BITS-1:0] near);
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return SAMPLE_BITS'($urandom);
		if (roll < 70)
			return SAMPLE_BITS'($signed($urandom_range(2047)) - 1024);
		if (roll < 82) begin
			case ($urandom_range(5))
				0:       return S_MAX;
				1:       return S_MIN;
				2:       return SAMPLE_BITS'(S_MAX - 1);
				3:       return SAMPLE_BITS'(S_MIN + 1);
				4:       return '0;
				default: return '1;
			endcase
		end
		return SAMPLE_BITS'(near + ($signed($urandom_range(8191)) - 4096));
	endfunction

	initial begin
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
		logic [LIMIT_BITS-1:0]         lim;
		int                            p;
		int                            n;

		arst_n    = 1'b0;
		pcm_valid = 1'b0;
		pcm       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset limit: priming frame, then full-scale and bit-pattern frames
		send_frame(S_MAX, S_MIN);
		send_frame(S_MAX, S_MAX);
		send_frame(S_MIN, S_MIN);
		send_frame(S_MAX, S_MIN);
		send_frame(S_MIN, S_MAX);
		send_frame('0, '0);
		send_frame('1, 24'sd1);
		send_frame(S_ALT, ~S_ALT);
		send_frame(~S_ALT, S_ALT);
		send_frame(S_MAX, S_MAX);
		send_frame(S_MAX, S_MAX);
		settle();
		// zero limit pins every integrator, so every bit is one
		write_limit(7'd0);
		send_frame(S_MIN, S_MAX);
		send_frame(S_MAX, S_MIN);
		send_frame('0, '0);
		settle();
		write_limit(7'd127);
		send_frame(S_MAX, S_MAX);
		send_frame(S_MAX, S_MAX);
		send_frame(S_MAX, S_MIN);
		send_frame(S_MIN, S_MIN);
		send_frame(S_MIN, S_MIN);
		settle();
		write_limit(7'd1);
		send_frame(S_MAX, S_MIN);
		send_frame(S_MIN, S_MAX);
		send_frame(24'sd4096, -24'sd4096);

		l = '0;
		r = '0;
		for (p = 0; p < 8; p++) begin
			settle();
			case (p)
				0:       lim = 7'd127;
				1:       lim = LIMIT_RESET;
				2:       lim = 7'd1;
				3:       lim = 7'd0;
				6:       lim = 7'd127;
				default: lim = LIMIT_BITS'($urandom_range(126, 1));
			endcase
			write_limit(lim);
			case (p % 4)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 51; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 51; end
				default: begin idle_pct = 8;  stall_pct = 8;  end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 0 && n == 12)
					hold_req = 1'b1;
				if (p == 4 && n == 28) begin
					pcm_valid <= 1'b0;
					wait (words_due == 0);
					@(negedge clk);
				end
				l = pick_sample(l);
				r = pick_sample(r);
				send_frame(l, r);
			end
		end

		// drain
		pcm_valid <= 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		wait (words_due == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && words_due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/pcmdsd_pkg.sv
rtl/core/pcmdsd_lane.sv
rtl/core/pcmdsd_merge.sv
rtl/core/pcm_to_dsd_sigma_delta_modulator_core.sv
bench/dsd_stream_checker.sv
bench/pcm_to_dsd_sigma_delta_modulator_core_tb.sv
